// ----- hw/rtl/tlbs_pkg.sv -----
// Shared constants, command codes and controller/datapath struct types
// for the table search core. No dependencies.
package tlbs_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int LEN_W       = ADDR_W + 1;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 11;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 10;

  // input word command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LINEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BINARY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic wr;          // store the accepted word in the table
    logic start_lin;   // latch key and count, clear scan index
    logic start_bin;   // latch key and count, set low/high bounds
    logic lin_rd;      // read at scan index, advance it
    logic bin_rd;      // read at midpoint, hold midpoint
    logic bin_upd;     // narrow bounds from last compare
    logic fin_lin_hit; // capture hit at last linear read position
    logic fin_bin_hit; // capture hit at held midpoint
    logic fin_miss;    // capture not-found
    logic out_load;    // move captured result into output register
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic lin_more;    // scan index below count
    logic rd_pend;     // linear read data valid this cycle
    logic eq;          // read data equals key
    logic bin_live;    // high bound at or above low bound
  } sts_t;

endpackage

// ----- hw/rtl/table_linear_and_binary_search_core.sv -----
// Top level of the table search core: joins controller and datapath.
// Uses tlbs_pkg, tlbs_ctrl, tlbs_dpath.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_stall    command, write_index, entry_value, search_key
//  out_     output     out_valid/out_stall  found, position
//  cfg_     input      cfg_wr_en            cfg_wr_data (entry_count)
//
// A write word (or an unused command) completes with the controller idle. A linear
// search scans up to the entry count: one table read per cycle on the
// single read port, with the compare in the following cycle. A binary
// search runs each probe as a read and then a compare. Reset clears the
// controller and entry count; table contents are undefined until written.
// out_stall holds a finished result in the output register; writes are
// still taken, and the next search runs to its end and waits in the
// controller, with the input stalled, until the output frees up.
module table_linear_and_binary_search_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tlbs_pkg::CMD_W-1:0]         in_command,
  input  logic [tlbs_pkg::POS_W-1:0]         in_write_index,
  input  logic signed [tlbs_pkg::DATA_W-1:0] in_entry_value,
  input  logic signed [tlbs_pkg::DATA_W-1:0] in_search_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [tlbs_pkg::POS_W-1:0]         out_position,
  input  logic                               cfg_wr_en,
  input  logic [tlbs_pkg::CFG_W-1:0]         cfg_wr_data
);

  tlbs_pkg::ctl_t ctl;
  tlbs_pkg::sts_t sts;

  tlbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ctl        (ctl),
    .sts        (sts)
  );

  tlbs_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_index    (in_write_index),
    .wr_value    (in_entry_value),
    .key         (in_search_key),
    .found       (out_found),
    .position    (out_position)
  );

endmodule

// ----- hw/rtl/tlbs_dpath.sv -----
// Datapath of the table search core: entry memory, scan and bound
// registers, compare logic and output payload register. Uses tlbs_pkg.
module tlbs_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlbs_pkg::ctl_t                     ctl,
  output tlbs_pkg::sts_t                     sts,
  input  logic                               cfg_wr_en,
  input  logic [tlbs_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic [tlbs_pkg::POS_W-1:0]         wr_index,
  input  logic signed [tlbs_pkg::DATA_W-1:0] wr_value,
  input  logic signed [tlbs_pkg::DATA_W-1:0] key,
  output logic                               found,
  output logic [tlbs_pkg::POS_W-1:0]         position
);

  localparam int AW = tlbs_pkg::ADDR_W;
  localparam int LW = tlbs_pkg::LEN_W;
  localparam int DW = tlbs_pkg::DATA_W;

  logic [DW-1:0]        mem [tlbs_pkg::MAX_ENTRIES];
  logic signed [DW-1:0] rdata_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  logic [tlbs_pkg::CFG_W-1:0] count_r;
  logic [LW-1:0]        n_sat;
  logic [LW-1:0]        n_r;
  logic signed [DW-1:0] key_r;
  logic [LW-1:0]        idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pos_r;
  logic [LW-1:0]        lo_r, lo_nxt;
  logic signed [LW:0]   hi_r, hi_nxt;
  logic [AW-1:0]        mid_r;
  logic [LW:0]          mid_sum;
  logic [AW-1:0]        mid;
  logic                 res_found_r;
  logic [AW-1:0]        res_pos_r;
  logic                 found_r;
  logic [tlbs_pkg::POS_W-1:0] position_r;

  // hold the entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // saturate the count to the table depth
  assign n_sat = (32'(count_r) > tlbs_pkg::MAX_ENTRIES) ?
                 LW'(tlbs_pkg::MAX_ENTRIES) : LW'(count_r);

  // midpoint of the live bounds; only used while high >= low >= 0
  assign mid_sum = (LW+1)'(lo_r) + (LW+1)'(hi_r[LW-1:0]);
  assign mid     = mid_sum[AW:1];

  // table write port
  always_ff @(posedge clk) begin
    if (ctl.wr && (32'(wr_index) < tlbs_pkg::MAX_ENTRIES)) begin
      mem[AW'(wr_index)] <= wr_value;
    end
  end

  // table read port, registered data
  assign rd_en   = ctl.lin_rd | ctl.bin_rd;
  assign rd_addr = ctl.lin_rd ? idx_r[AW-1:0] : mid;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // scan and bound next values
  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = ctl.lin_rd;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    if (ctl.start_lin) begin
      idx_nxt = '0;
    end else if (ctl.lin_rd) begin
      idx_nxt = idx_r + LW'(1);
    end
    if (ctl.start_bin) begin
      lo_nxt = '0;
      hi_nxt = $signed({1'b0, n_sat}) - (LW+1)'(1);
    end else if (ctl.bin_upd) begin
      if (rdata_r > key_r) begin
        hi_nxt = $signed({1'b0, LW'(mid_r)}) - (LW+1)'(1);
      end else begin
        lo_nxt = LW'(mid_r) + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    if (ctl.start_lin || ctl.start_bin) begin
      key_r <= key;
      n_r   <= n_sat;
    end
    if (ctl.lin_rd) begin
      pos_r <= idx_r[AW-1:0];
    end
    if (ctl.bin_rd) begin
      mid_r <= mid;
    end
  end

  // capture result, then move it to the output register
  always_ff @(posedge clk) begin
    if (ctl.fin_lin_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= pos_r;
    end else if (ctl.fin_bin_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= mid_r;
    end else if (ctl.fin_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end
    if (ctl.out_load) begin
      found_r    <= res_found_r;
      position_r <= tlbs_pkg::POS_W'(res_pos_r);
    end
  end

  assign found    = found_r;
  assign position = position_r;

  // status to controller
  assign sts.lin_more = idx_r < n_r;
  assign sts.rd_pend  = pend_r;
  assign sts.eq       = rdata_r == key_r;
  assign sts.bin_live = hi_r >= $signed({1'b0, lo_r});

endmodule

// ----- hw/rtl/tlbs_ctrl.sv -----
// Controller of the table search core: input/output handshake and
// search sequencing state machine. Uses tlbs_pkg.
module tlbs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tlbs_pkg::CMD_W-1:0]   in_command,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tlbs_pkg::ctl_t               ctl,
  input  tlbs_pkg::sts_t               sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LIN  = 3'd1;
  localparam logic [2:0] S_BREQ = 3'd2;
  localparam logic [2:0] S_BCMP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;
  logic       out_free;

  assign in_stall  = state_r != S_IDLE;
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // sequence one word at a time
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (in_command == tlbs_pkg::CMD_WRITE) begin
            ctl.wr = 1'b1;
          end else if (in_command == tlbs_pkg::CMD_LINEAR) begin
            ctl.start_lin = 1'b1;
            state_nxt     = S_LIN;
          end else if (in_command == tlbs_pkg::CMD_BINARY) begin
            ctl.start_bin = 1'b1;
            state_nxt     = S_BREQ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LIN: begin
        // one read issued per cycle, each compared once its registered data arrives
        priority if (sts.rd_pend && sts.eq) begin
          ctl.fin_lin_hit = 1'b1;
          state_nxt       = S_DONE;
        end else if (!sts.lin_more && !sts.rd_pend) begin
          ctl.fin_miss = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          ctl.lin_rd = sts.lin_more;
        end
      end
      S_BREQ: begin
        if (sts.bin_live) begin
          ctl.bin_rd = 1'b1;
          state_nxt  = S_BCMP;
        end else begin
          ctl.fin_miss = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_BCMP: begin
        if (sts.eq) begin
          ctl.fin_bin_hit = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          ctl.bin_upd = 1'b1;
          state_nxt   = S_BREQ;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> out_free)
    else $error("result loaded over a stalled word");

  // a linear search word starts the scan in the next cycle
  a_lin_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_command == tlbs_pkg::CMD_LINEAR) |=> state_r == S_LIN)
    else $error("linear search did not start");

  // a binary compare always follows its probe read
  a_bcmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BCMP) |-> $past(ctl.bin_rd))
    else $error("binary compare without a probe read");

  // each finished search reaches the result stage
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin_lin_hit || ctl.fin_bin_hit || ctl.fin_miss) |=> state_r == S_DONE)
    else $error("finished search did not reach result stage");

endmodule
